@@ hw/rtl/flre_pkg.sv @@
// ----------------------------------------------------------------------------
// flre_pkg
// Shared types and constants of the flash range erase planner.
// ----------------------------------------------------------------------------
package flre_pkg;

  localparam int SECTOR_COUNT = 512;
  localparam int SECTOR_BYTES = 4096;

  localparam int SEC_IN_W   = 9;
  localparam int SEC_W      = 10;
  localparam int LIMIT_W    = 13;
  localparam int OPCODE_W   = 8;
  localparam int ADDR_W     = 24;
  localparam int SEC_SHIFT  = $clog2(SECTOR_BYTES);

  localparam logic [LIMIT_W-1:0] SECTOR_LIMIT = LIMIT_W'(SECTOR_COUNT);

  localparam logic [OPCODE_W-1:0] OP_NONE      = 8'h00;
  localparam logic [OPCODE_W-1:0] OP_ERASE_64K = 8'hD8;
  localparam logic [OPCODE_W-1:0] OP_ERASE_32K = 8'h52;
  localparam logic [OPCODE_W-1:0] OP_ERASE_4K  = 8'h20;

  localparam logic [SEC_W-1:0] SECTORS_64K = 10'd16;
  localparam logic [SEC_W-1:0] SECTORS_32K = 10'd8;
  localparam logic [SEC_W-1:0] SECTORS_4K  = 10'd1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cmd_last;
  } dp_status_t;

endpackage

@@ hw/rtl/flash_range_erase_planner.sv @@
// ----------------------------------------------------------------------------
// flash_range_erase_planner
// Splits a sector range into 64 KB, 32 KB and 4 KB erase commands.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         in_valid/in_ready    first_sector, last_sector
//  command   out        out_valid/out_ready  erase_opcode, byte_address,
//                                            range_error, last
//
//  A request word is taken only in idle; a request giving N commands (up to
//  39 words) occupies the sequencer from its load until its last issue.
//  Size selection makes one command word per cycle while the output is free.
//  A held output word stalls the sequencer; the next request is taken while
//  the final word still waits. Reset (rst, synchronous) returns to idle.
// ----------------------------------------------------------------------------
module flash_range_erase_planner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [flre_pkg::SEC_IN_W-1:0]     first_sector,
  input  logic [flre_pkg::SEC_IN_W-1:0]     last_sector,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [flre_pkg::OPCODE_W-1:0]     erase_opcode,
  output logic [flre_pkg::ADDR_W-1:0]       byte_address,
  output logic                              range_error,
  output logic                              last
);
  import flre_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  flre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  flre_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .first_sector (first_sector),
    .last_sector  (last_sector),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .erase_opcode (erase_opcode),
    .byte_address (byte_address),
    .range_error  (range_error),
    .last         (last)
  );

endmodule

@@ hw/rtl/flre_ctrl.sv @@
// ----------------------------------------------------------------------------
// flre_ctrl
// Request sequencer: takes one request, then issues commands until the last.
// ----------------------------------------------------------------------------
module flre_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  flre_pkg::dp_status_t  status,
  output flre_pkg::ctl_cmd_t    cmd
);
  import flre_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.issue = 1'b1;
          if (status.cmd_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/flre_datapath.sv @@
// ----------------------------------------------------------------------------
// flre_datapath
// Range registers, greedy erase size selection and the output word register.
// ----------------------------------------------------------------------------
module flre_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [flre_pkg::SEC_IN_W-1:0]     first_sector,
  input  logic [flre_pkg::SEC_IN_W-1:0]     last_sector,
  input  flre_pkg::ctl_cmd_t                cmd,
  output flre_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [flre_pkg::OPCODE_W-1:0]     erase_opcode,
  output logic [flre_pkg::ADDR_W-1:0]       byte_address,
  output logic                              range_error,
  output logic                              last
);
  import flre_pkg::*;

  logic [SEC_W-1:0]    cur;
  logic [SEC_W-1:0]    rem;
  logic                err_flag;

  logic [SEC_IN_W-1:0] lo;
  logic [SEC_IN_W-1:0] hi;
  logic [SEC_W-1:0]    count;
  logic                in_err;
  logic [SEC_W-1:0]    step;
  logic [OPCODE_W-1:0] sel_op;
  logic [SEC_W-1:0]    rem_next;

  always_comb begin
    in_err = (LIMIT_W'(first_sector) >= SECTOR_LIMIT) ||
             (LIMIT_W'(last_sector) >= SECTOR_LIMIT);
    if (first_sector > last_sector) begin
      lo = last_sector;
      hi = first_sector;
    end else begin
      lo = first_sector;
      hi = last_sector;
    end
    count = SEC_W'(hi) - SEC_W'(lo) + SECTORS_4K;
  end

  always_comb begin
    priority if (rem >= SECTORS_64K) begin
      step   = SECTORS_64K;
      sel_op = OP_ERASE_64K;
    end else if (rem >= SECTORS_32K) begin
      step   = SECTORS_32K;
      sel_op = OP_ERASE_32K;
    end else begin
      step   = SECTORS_4K;
      sel_op = OP_ERASE_4K;
    end
    rem_next = rem - step;
  end

  assign status.out_free = !out_valid || out_ready;
  assign status.cmd_last = err_flag || (rem_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur       <= '0;
      rem       <= '0;
      err_flag  <= 1'b0;
    end else begin
      if (cmd.issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        err_flag <= in_err;
        if (!in_err) begin
          cur <= SEC_W'(lo);
          rem <= count;
        end
      end else if (cmd.issue && !err_flag) begin
        cur <= cur + step;
        rem <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      if (err_flag) begin
        erase_opcode <= OP_NONE;
        byte_address <= '0;
        range_error  <= 1'b1;
        last         <= 1'b1;
      end else begin
        erase_opcode <= sel_op;
        byte_address <= ADDR_W'(cur) << SEC_SHIFT;
        range_error  <= 1'b0;
        last         <= (rem_next == '0);
      end
    end
  end

endmodule

@@ hw/rtl/flre_checker.sv @@
// ----------------------------------------------------------------------------
// flre_checker
// Port-level checks of the erase planner, bound to the top level.
// ----------------------------------------------------------------------------
module flre_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [flre_pkg::SEC_IN_W-1:0]     first_sector,
  input logic [flre_pkg::SEC_IN_W-1:0]     last_sector,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [flre_pkg::OPCODE_W-1:0]     erase_opcode,
  input logic [flre_pkg::ADDR_W-1:0]       byte_address,
  input logic                              range_error,
  input logic                              last
);
  import flre_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(erase_opcode) &&
      $stable(byte_address) && $stable(range_error) && $stable(last))
    else $error("command word changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last && erase_opcode == OP_NONE &&
      byte_address == '0)
    else $error("malformed range error word");

  a_opcode: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |-> erase_opcode == OP_ERASE_64K ||
      erase_opcode == OP_ERASE_32K || erase_opcode == OP_ERASE_4K)
    else $error("unknown erase opcode");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while planning");

endmodule

bind flash_range_erase_planner flre_checker u_flre_checker (.*);
